### src/least_loaded_server_heap_unit_assert.svh
// Assertion macros used by the checker file of the server heap unit.
`ifndef LEAST_LOADED_SERVER_HEAP_UNIT_ASSERT_SVH
`define LEAST_LOADED_SERVER_HEAP_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define LLSH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define LLSH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/llsh_pkg.sv
// Shared types and constants of the server heap unit.
package llsh_pkg;
	localparam int CAPACITY_DEF = 64;
	localparam int CNT_W_DEF = $clog2(CAPACITY_DEF + 1);

	typedef enum logic [2:0] {
		ACT_INSERT     = 3'd0,
		ACT_POP        = 3'd1,
		ACT_PEEK       = 3'd2,
		ACT_UPDATE     = 3'd3,
		ACT_DISCONNECT = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] port;
		logic [15:0] load;
		logic [15:0] tmo;
		logic [31:0] seen;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	typedef struct packed {
		logic [2:0] action;
		ent_t       ent;
	} req_t;

	typedef struct packed {
		status_t status;
		ent_t    ent;
	} res_t;
endpackage

### src/llsh_if.sv
// Channel interfaces of the server heap unit: request, result and configuration.
interface llsh_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [31:0] server_addr;
	logic [15:0] server_port;
	logic [15:0] load;
	logic [15:0] timeout;
	logic [31:0] now;

	modport source (output valid, action, server_addr, server_port, load, timeout, now,
		input ready);
	modport sink (input valid, action, server_addr, server_port, load, timeout, now,
		output ready);
endinterface

interface llsh_out_if #(parameter int CW = llsh_pkg::CNT_W_DEF);
	logic          valid;
	logic          ready;
	logic [1:0]    status;
	logic [31:0]   out_addr;
	logic [15:0]   out_port;
	logic [15:0]   out_load;
	logic [15:0]   out_timeout;
	logic [31:0]   out_last_seen;
	logic [CW-1:0] entry_count;

	modport source (output valid, status, out_addr, out_port, out_load, out_timeout,
		out_last_seen, entry_count, input ready);
	modport sink (input valid, status, out_addr, out_port, out_load, out_timeout,
		out_last_seen, entry_count, output ready);
endinterface

interface llsh_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### src/llsh_mem.sv
// Heap slot memory: one write port, one read port with registered read data.
module llsh_mem #(
	parameter int DEPTH = llsh_pkg::CAPACITY_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [llsh_pkg::ENT_W-1:0] wdata,
	input  logic [AW-1:0]         raddr,
	output logic [llsh_pkg::ENT_W-1:0] rdata
);
	import llsh_pkg::*;

	logic [ENT_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### src/llsh_ctrl.sv
// Heap sequencer: key scan, sift-up, sift-down and removal over the slot memory.
module llsh_ctrl #(
	parameter int CAPACITY = llsh_pkg::CAPACITY_DEF,
	parameter int AW = $clog2(CAPACITY),
	parameter int CW = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  llsh_pkg::req_t     req,
	input  logic [15:0]        grace,
	input  logic               out_free,
	output logic               idle,
	output logic               done,
	output llsh_pkg::res_t     res,
	output logic [CW-1:0]      count,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output llsh_pkg::ent_t     mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  llsh_pkg::ent_t     mem_rdata
);
	import llsh_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_SCAN   = 14'b00000000000010,
		S_POP    = 14'b00000000000100,
		S_PK_RD  = 14'b00000000001000,
		S_PK_CHK = 14'b00000000010000,
		S_RM     = 14'b00000000100000,
		S_RM_LD  = 14'b00000001000000,
		S_DN_L   = 14'b00000010000000,
		S_DN_R   = 14'b00000100000000,
		S_DN_CMP = 14'b00001000000000,
		S_UP_RD  = 14'b00010000000000,
		S_UP_CMP = 14'b00100000000000,
		S_REINS  = 14'b01000000000000,
		S_DONE   = 14'b10000000000000
	} state_t;

	state_t        state_q;
	action_t       op_q;
	ent_t          new_q;
	ent_t          mov_q;
	ent_t          child_q;
	res_t          res_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] scan_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] cidx_q;
	logic [AW-1:0] chk_idx_s1;
	logic          chk_vld_s1;
	logic          moved_q;
	logic          reins_q;
	logic          rsel_q;

	logic [CW:0]   lc_w;
	logic [CW:0]   rc_w;
	logic          has_l;
	logic          has_r;
	logic [AW-1:0] parent;
	logic [AW-1:0] last;
	logic          right_wins;
	ent_t          best;
	logic [AW-1:0] best_idx;
	logic          up_swap;
	logic          dn_swap;
	logic [32:0]   idle_diff;
	logic [16:0]   limit;
	logic          expire;
	logic          hit;
	ent_t          refreshed;
	state_t        fin;

	assign lc_w = (CW + 1)'({pos_q, 1'b1});
	assign rc_w = lc_w + 1'b1;
	assign has_l = lc_w < {1'b0, cnt_q};
	assign has_r = rc_w < {1'b0, cnt_q};
	assign parent = (pos_q - 1'b1) >> 1;
	assign last = AW'(cnt_q - 1'b1);
	assign right_wins = rsel_q && (mem_rdata.load < child_q.load);
	assign best = right_wins ? mem_rdata : child_q;
	assign best_idx = right_wins ? cidx_q + 1'b1 : cidx_q;
	assign up_swap = mov_q.load < mem_rdata.load;
	assign dn_swap = best.load < mov_q.load;
	// Idle time is signed: a last-seen time ahead of now never expires.
	assign idle_diff = {1'b0, new_q.seen} - {1'b0, mem_rdata.seen};
	assign limit = {1'b0, mem_rdata.tmo} + {1'b0, grace};
	assign expire = !idle_diff[32] && (idle_diff[31:0] > 32'(limit));
	assign hit = chk_vld_s1 && (mem_rdata.addr == new_q.addr)
		&& (mem_rdata.port == new_q.port);

	always_comb begin
		refreshed = mem_rdata;
		refreshed.seen = new_q.seen;
	end

	// Where a removal or sift ends depends on the action under way.
	always_comb begin
		if (op_q == ACT_PEEK) begin
			fin = S_PK_RD;
		end else if (reins_q) begin
			fin = S_REINS;
		end else begin
			fin = S_DONE;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = mov_q;
		mem_raddr = '0;
		unique case (state_q)
			S_SCAN: begin
				mem_raddr = AW'(scan_q);
				if (hit && op_q == ACT_UPDATE && mem_rdata.load == new_q.load) begin
					mem_we = 1'b1;
					mem_waddr = chk_idx_s1;
					mem_wdata = refreshed;
				end
			end
			S_RM: mem_raddr = last;
			S_DN_L: begin
				mem_raddr = AW'(lc_w);
				mem_we = !has_l && moved_q;
			end
			S_DN_R: mem_raddr = AW'(rc_w);
			S_DN_CMP: begin
				mem_we = dn_swap || moved_q;
				mem_wdata = dn_swap ? best : mov_q;
			end
			S_UP_RD: begin
				mem_raddr = parent;
				mem_we = (pos_q == '0);
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				mem_wdata = up_swap ? mem_rdata : mov_q;
			end
			default: mem_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			reins_q <= 1'b0;
			moved_q <= 1'b0;
			chk_vld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= action_t'(req.action);
						new_q <= req.ent;
						reins_q <= 1'b0;
						case (req.action)
							ACT_INSERT: begin
								if (cnt_q == CW'(CAPACITY)) begin
									res_q <= '{status: ST_FULL, ent: '0};
									state_q <= S_DONE;
								end else begin
									res_q <= '{status: ST_OK, ent: req.ent};
									pos_q <= AW'(cnt_q);
									cnt_q <= cnt_q + 1'b1;
									mov_q <= req.ent;
									state_q <= S_UP_RD;
								end
							end
							ACT_POP: begin
								if (cnt_q == '0) begin
									res_q <= '{status: ST_EMPTY, ent: '0};
									state_q <= S_DONE;
								end else begin
									state_q <= S_POP;
								end
							end
							ACT_PEEK: state_q <= S_PK_RD;
							ACT_UPDATE, ACT_DISCONNECT: begin
								scan_q <= '0;
								chk_vld_s1 <= 1'b0;
								state_q <= S_SCAN;
							end
							default: begin
								res_q <= '{status: ST_OK, ent: '0};
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						chk_vld_s1 <= 1'b0;
						pos_q <= chk_idx_s1;
						if (op_q == ACT_DISCONNECT) begin
							res_q <= '{status: ST_OK, ent: mem_rdata};
							state_q <= S_RM;
						end else if (mem_rdata.load == new_q.load) begin
							res_q <= '{status: ST_OK, ent: refreshed};
							state_q <= S_DONE;
						end else begin
							new_q.tmo <= mem_rdata.tmo;
							reins_q <= 1'b1;
							state_q <= S_RM;
						end
					end else if (scan_q < cnt_q) begin
						chk_vld_s1 <= 1'b1;
						chk_idx_s1 <= AW'(scan_q);
						scan_q <= scan_q + 1'b1;
					end else begin
						chk_vld_s1 <= 1'b0;
						res_q <= '{status: ST_NOT_FOUND, ent: '0};
						state_q <= S_DONE;
					end
				end
				S_POP: begin
					res_q <= '{status: ST_OK, ent: mem_rdata};
					pos_q <= '0;
					state_q <= S_RM;
				end
				S_PK_RD: begin
					if (cnt_q == '0) begin
						res_q <= '{status: ST_EMPTY, ent: '0};
						state_q <= S_DONE;
					end else begin
						state_q <= S_PK_CHK;
					end
				end
				S_PK_CHK: begin
					if (expire) begin
						pos_q <= '0;
						state_q <= S_RM;
					end else begin
						res_q <= '{status: ST_OK, ent: mem_rdata};
						state_q <= S_DONE;
					end
				end
				S_RM: begin
					cnt_q <= cnt_q - 1'b1;
					moved_q <= 1'b0;
					// Removing the last slot needs no fill from the end.
					state_q <= (pos_q == last) ? fin : S_RM_LD;
				end
				S_RM_LD: begin
					mov_q <= mem_rdata;
					state_q <= S_DN_L;
				end
				S_DN_L: begin
					if (has_l) begin
						cidx_q <= AW'(lc_w);
						state_q <= S_DN_R;
					end else begin
						state_q <= moved_q ? fin : S_UP_RD;
					end
				end
				S_DN_R: begin
					child_q <= mem_rdata;
					rsel_q <= has_r;
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (dn_swap) begin
						pos_q <= best_idx;
						moved_q <= 1'b1;
						state_q <= S_DN_L;
					end else begin
						// An entry that did not sink may still have to rise.
						state_q <= moved_q ? fin : S_UP_RD;
					end
				end
				S_UP_RD: state_q <= (pos_q == '0) ? fin : S_UP_CMP;
				S_UP_CMP: begin
					if (up_swap) begin
						pos_q <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= fin;
					end
				end
				S_REINS: begin
					res_q <= '{status: ST_OK, ent: new_q};
					pos_q <= AW'(cnt_q);
					cnt_q <= cnt_q + 1'b1;
					mov_q <= new_q;
					reins_q <= 1'b0;
					state_q <= S_UP_RD;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE) && out_free;
	assign res = res_q;
	assign count = cnt_q;
endmodule

### src/least_loaded_server_heap_unit.sv
// Top level of the server heap unit: config register, sequencer, slot memory, result register.
//
//  channel   dir  handshake          payload
//  in_ch     in   valid / ready      action, server_addr, server_port, load, timeout, now
//  out_ch    out  valid / ready      status, out_* entry fields, entry_count
//  cfg       in   valid / ready      data = grace_seconds
//
// One item at a time. Insert sifts up, with a parent read and a compare per heap level; pop
// and disconnect refill the hole from the last slot and sift down, with left read, right read
// and compare per level, or sift up if the entry does not sink. Update and disconnect first
// scan one slot per cycle; an update that re-keys an entry then removes and reinserts it. Peek
// repeats a removal for each expired top entry. All reads share the single memory read port.
// Reset empties the heap and clears grace_seconds; slots are not cleared. The next item is
// taken while a result waits in the output register.
module least_loaded_server_heap_unit #(
	parameter int CAPACITY = llsh_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	llsh_in_if.sink   in_ch,
	llsh_out_if.source out_ch,
	llsh_cfg_if.sink  cfg
);
	import llsh_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [15:0]   grace_q;
	logic          idle;
	logic          done;
	logic          out_free;
	req_t          req;
	res_t          res;
	logic [CW-1:0] count;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	ent_t          mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [ENT_W-1:0] mem_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_q <= '0;
		end else if (cfg.valid) begin
			grace_q <= cfg.data;
		end
	end

	assign req.action = in_ch.action;
	assign req.ent = '{addr: in_ch.server_addr, port: in_ch.server_port,
		load: in_ch.load, tmo: in_ch.timeout, seen: in_ch.now};
	assign in_ch.ready = idle;
	assign out_free = !out_ch.valid || out_ch.ready;

	llsh_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(in_ch.valid),
		.req(req),
		.grace(grace_q),
		.out_free(out_free),
		.idle(idle),
		.done(done),
		.res(res),
		.count(count),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(ent_t'(mem_rdata))
	);

	llsh_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (done) begin
			out_ch.valid <= 1'b1;
		end else if (out_ch.ready) begin
			out_ch.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_ch.status <= res.status;
			out_ch.out_addr <= res.ent.addr;
			out_ch.out_port <= res.ent.port;
			out_ch.out_load <= res.ent.load;
			out_ch.out_timeout <= res.ent.tmo;
			out_ch.out_last_seen <= res.ent.seen;
			out_ch.entry_count <= count;
		end
	end
endmodule

### src/llsh_chk.sv
// Port-level checker of the server heap unit, bound to the top level.
module llsh_chk #(
	parameter int CAPACITY = llsh_pkg::CAPACITY_DEF,
	parameter int CW = $clog2(CAPACITY + 1)
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic [1:0]    status,
	input logic [CW-1:0] entry_count
);
	import llsh_pkg::*;

	`include "least_loaded_server_heap_unit_assert.svh"

	`LLSH_ASSERT_NOW(a_full_count, out_valid && status == ST_FULL, entry_count == CW'(CAPACITY), "full reported below capacity")
	`LLSH_ASSERT_NOW(a_empty_count, out_valid && status == ST_EMPTY, entry_count == '0, "empty reported with entries")
	`LLSH_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item accepted while busy")
	`LLSH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(entry_count), "stalled result changed")
endmodule

bind least_loaded_server_heap_unit llsh_chk #(.CAPACITY(CAPACITY)) u_llsh_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.status(out_ch.status),
	.entry_count(out_ch.entry_count)
);
